// ===== rtl/core/binary_trie_route_lookup_assert.svh =====
// Assertion macros shared by the route lookup RTL
`ifndef BINARY_TRIE_ROUTE_LOOKUP_ASSERT_SVH
`define BINARY_TRIE_ROUTE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define BTRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BTRL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/btrl_pkg.sv =====
// Shared types and codes of the trie route lookup
`default_nettype none
package btrl_pkg;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_LAYER_FULL = 2'd1;
  localparam logic [1:0] STAT_HOPS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    WAVE_PROBE,
    WAVE_COMMIT,
    WAVE_SEARCH
  } wave_mode_t;

  // control part of the wave that walks the cell row
  typedef struct packed {
    logic       vld;
    wave_mode_t mode;
    logic       exists;
    logic       full;
  } wave_ctl_t;

  typedef struct packed {
    logic start;
    logic append;
    logic lookup;
  } hop_ctl_t;

  typedef struct packed {
    logic done;
    logic found;
    logic full;
  } hop_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMMIT,
    ST_SEARCH,
    ST_LOOKUP,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/btrl_cell.sv =====
// One trie layer: node memory, fill counter and the wave step for that layer
`default_nettype none
module btrl_cell import btrl_pkg::*; #(
  parameter int LAYER = 0,
  parameter int NPL   = 1024,
  parameter int AW    = 32,
  parameter int NW    = 10,
  parameter int HW    = 6,
  parameter int LW    = 6
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wave_ctl_t       ctl_i,
  input  wire  [NW-1:0]   cur_i,
  input  wire  [AW-1:0]   addr_i,
  input  wire  [LW-1:0]   n_i,
  input  wire  [HW-1:0]   hop_i,
  input  wire  [NW-1:0]   fill_nxt_i,
  output wave_ctl_t       ctl_o,
  output logic [NW-1:0]   cur_o,
  output logic [AW-1:0]   addr_o,
  output logic [LW-1:0]   n_o,
  output logic [HW-1:0]   hop_o,
  output logic [NW-1:0]   fill_o
);

  localparam int             EW      = 2 * NW + HW;
  localparam int             BI      = (LAYER < AW) ? LAYER : 0;
  localparam logic [LW-1:0]  LAYER_L = LW'(LAYER);
  localparam logic [NW-1:0]  FULL_AT = NW'(NPL - 1);

  logic [EW-1:0] mem [NPL];
  logic [EW-1:0] rd_r;
  logic [EW-1:0] entry;
  logic [EW-1:0] wr_data;
  wave_ctl_t     ctl_r;
  logic [NW-1:0] cur_r;
  logic [AW-1:0] addr_r;
  logic [LW-1:0] n_r;
  logic [HW-1:0] hop_r;
  logic [NW-1:0] fill_r;
  logic [NW-1:0] child;
  logic [NW-1:0] next_idx;
  logic [HW-1:0] node_hop;
  logic          node_valid;
  logic          in_range;
  logic          step;
  logic          b;
  logic          wr_en;

  always_ff @(posedge clk) begin
    rd_r   <= mem[cur_i];
    cur_r  <= cur_i;
    addr_r <= addr_i;
    n_r    <= n_i;
    hop_r  <= hop_i;
    if (wr_en) begin
      mem[cur_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      fill_r <= '0;
    end else begin
      ctl_r <= ctl_i;
      if (wr_en && !node_valid) begin
        fill_r <= fill_r + NW'(1);
      end
    end
  end

  // root is valid once written; deeper nodes exist only behind a child pointer
  assign node_valid = (LAYER == 0) ? (fill_r != '0) : ctl_r.exists;
  assign entry      = node_valid ? rd_r : '0;
  assign b          = (LAYER < AW) && addr_r[BI];
  assign child      = b ? entry[EW-1 -: NW] : entry[HW +: NW];
  assign node_hop   = entry[HW-1:0];
  assign in_range   = (LAYER_L <= n_r);
  assign step       = (LAYER_L < n_r);
  assign next_idx   = (ctl_r.exists && child != '0) ? child : fill_nxt_i + NW'(1);
  assign wr_en      = ctl_r.vld && ctl_r.mode == WAVE_COMMIT && in_range;

  always_comb begin
    wr_data = entry;
    if (step) begin
      if (b) begin
        wr_data[EW-1 -: NW] = next_idx;
      end else begin
        wr_data[HW +: NW] = next_idx;
      end
    end else begin
      wr_data[HW-1:0] = hop_r;
    end
  end

  always_comb begin
    ctl_o       = ctl_r;
    cur_o       = child;
    addr_o      = addr_r;
    n_o         = n_r;
    hop_o       = hop_r;
    ctl_o.exists = ctl_r.exists && child != '0 && (LAYER < AW);
    case (ctl_r.mode)
      WAVE_SEARCH: begin
        if (ctl_r.exists && node_hop != '0) begin
          hop_o = node_hop;
        end
      end
      WAVE_PROBE: begin
        ctl_o.exists = ctl_r.exists && step && child != '0;
        if (!ctl_r.exists && in_range && LAYER >= 1 && fill_r >= FULL_AT) begin
          ctl_o.full = 1'b1;
        end
      end
      WAVE_COMMIT: begin
        ctl_o.exists = ctl_r.exists && step && child != '0;
        cur_o        = next_idx;
      end
      default: begin
        ctl_o.vld = 1'b0;
      end
    endcase
  end

  assign fill_o = fill_r;

endmodule
`default_nettype wire

// ===== rtl/core/btrl_hop_table.sv =====
// Next-hop table: storage, count, sequential dedup scan and index lookup
`default_nettype none
module btrl_hop_table import btrl_pkg::*; #(
  parameter int NEXT_HOPS = 63,
  parameter int HW        = 6
) (
  input  wire             clk,
  input  wire             rst_n,
  input  hop_ctl_t        ctl_i,
  input  wire  [31:0]     key_addr_i,
  input  wire  [7:0]      key_port_i,
  input  wire  [HW-1:0]   lk_idx_i,
  output hop_stat_t       stat_o,
  output logic [HW-1:0]   fidx_o,
  output logic [HW-1:0]   count_o,
  output logic [31:0]     rd_addr_o,
  output logic [7:0]      rd_port_o
);

  logic [39:0]   mem [NEXT_HOPS + 1];
  logic [39:0]   rd_r;
  logic [31:0]   key_addr_r;
  logic [7:0]    key_port_r;
  logic [HW-1:0] count_r;
  logic [HW:0]   k_r;
  logic [HW-1:0] pk_r;
  logic [HW-1:0] fidx_r;
  logic [HW-1:0] raddr;
  logic          pend_r;
  logic          busy_r;
  logic          found_r;
  logic          issue;
  logic          match;

  assign issue = busy_r && !found_r && (k_r <= {1'b0, count_r});
  assign match = pend_r && rd_r == {key_addr_r, key_port_r};
  assign raddr = ctl_i.lookup ? lk_idx_i : k_r[HW-1:0];

  always_ff @(posedge clk) begin
    if (ctl_i.lookup || issue) begin
      rd_r <= mem[raddr];
    end
    if (ctl_i.append) begin
      mem[count_r + HW'(1)] <= {key_addr_r, key_port_r};
    end
    if (ctl_i.start) begin
      key_addr_r <= key_addr_i;
      key_port_r <= key_port_i;
    end
    pk_r <= k_r[HW-1:0];
    if (match && !found_r) begin
      fidx_r <= pk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
      pend_r  <= 1'b0;
      busy_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (ctl_i.append) begin
        count_r <= count_r + HW'(1);
      end
      if (ctl_i.start) begin
        busy_r  <= 1'b1;
        found_r <= 1'b0;
        pend_r  <= 1'b0;
        k_r     <= (HW + 1)'(1);
      end else if (busy_r) begin
        pend_r <= issue;
        if (issue) begin
          k_r <= k_r + (HW + 1)'(1);
        end
        if (match) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  assign stat_o.done  = busy_r && !ctl_i.start && (found_r || (!issue && !pend_r));
  assign stat_o.found = found_r;
  assign stat_o.full  = ({1'b0, count_r} >= (HW + 1)'(NEXT_HOPS));
  assign fidx_o       = fidx_r;
  assign count_o      = count_r;
  assign rd_addr_o    = rd_r[39:8];
  assign rd_port_o    = rd_r[7:0];

endmodule
`default_nettype wire

// ===== rtl/core/binary_trie_route_lookup.sv =====
// Top level of the binary trie route lookup: controller, cell row and hop table
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  in       | in_valid/in_stall  | opcode, dest_address, prefix_length, hop_*
//  out      | out_valid/out_stall| hop_index, found_address, found_port, status
//
// One item at a time. A search is one wave down the row of ADDRESS_BITS+1 layer
// cells (one cell per cycle) plus a hop table read when a hop was found.
// An insert runs a probe wave alongside a dedup scan of the hop table (one entry
// a cycle), then a commit wave once both the probe wave and the scan over the
// used hop entries are done.
// Reset is synchronous; nodes beyond each layer fill count read as empty.
// A result waits in the output register while out_stall is high.
`default_nettype none
`include "binary_trie_route_lookup_assert.svh"
module binary_trie_route_lookup import btrl_pkg::*; #(
  parameter int NODES_PER_LAYER = 1024,
  parameter int NEXT_HOPS       = 63,
  parameter int ADDRESS_BITS    = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_opcode,
  input  wire  [31:0] in_dest_address,
  input  wire  [5:0]  in_prefix_length,
  input  wire  [31:0] in_hop_address,
  input  wire  [7:0]  in_hop_port,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [5:0]  out_hop_index,
  output logic [31:0] out_found_address,
  output logic [7:0]  out_found_port,
  output logic [1:0]  out_status
);

  localparam int AW     = ADDRESS_BITS;
  localparam int LAYERS = ADDRESS_BITS + 1;
  localparam int NW     = $clog2(NODES_PER_LAYER);
  localparam int HW     = $clog2(NEXT_HOPS + 1);
  localparam int LW     = $clog2(ADDRESS_BITS + 1);

  state_t        state_r, state_nxt;
  wave_ctl_t     ctl_w  [LAYERS + 1];
  logic [NW-1:0] cur_w  [LAYERS + 1];
  logic [AW-1:0] addr_w [LAYERS + 1];
  logic [LW-1:0] n_w    [LAYERS + 1];
  logic [HW-1:0] hop_w  [LAYERS + 1];
  logic [NW-1:0] fill_w [LAYERS];

  wave_ctl_t     launch_ctl_r;
  logic [AW-1:0] launch_addr_r;
  logic [LW-1:0] launch_n_r;
  logic [HW-1:0] launch_hop_r;
  logic          wdone_r;
  logic          full_r;
  logic [HW-1:0] res_idx_r;
  logic [31:0]   res_addr_r;
  logic [7:0]    res_port_r;
  logic [1:0]    res_stat_r;
  logic          out_valid_r;
  logic [5:0]    out_idx_r;
  logic [31:0]   out_addr_r;
  logic [7:0]    out_port_r;
  logic [1:0]    out_stat_r;

  hop_ctl_t      hop_ctl;
  hop_stat_t     hop_stat;
  logic [HW-1:0] hop_fidx;
  logic [HW-1:0] hop_count;
  logic [31:0]   hop_rd_addr;
  logic [7:0]    hop_rd_port;
  logic [HW-1:0] new_idx;
  logic [LW-1:0] n_sat;
  logic          accept;
  logic          wave_done;
  logic          probe_ready;
  logic          out_free;

  assign accept      = in_valid && !in_stall;
  assign wave_done   = ctl_w[LAYERS].vld;
  assign probe_ready = (wdone_r || wave_done) && hop_stat.done;
  assign out_free    = !out_valid_r || !out_stall;
  assign new_idx     = hop_stat.found ? hop_fidx : hop_count + HW'(1);
  assign n_sat       = (in_prefix_length > ADDRESS_BITS) ? LW'(ADDRESS_BITS)
                                                         : LW'(in_prefix_length);

  assign ctl_w[0]  = launch_ctl_r;
  assign cur_w[0]  = '0;
  assign addr_w[0] = launch_addr_r;
  assign n_w[0]    = launch_n_r;
  assign hop_w[0]  = launch_hop_r;

  for (genvar i = 0; i < LAYERS; i++) begin : g_cell
    logic [NW-1:0] fill_nxt;
    if (i < LAYERS - 1) begin : g_mid
      assign fill_nxt = fill_w[i + 1];
    end else begin : g_last
      assign fill_nxt = '0;
    end
    btrl_cell #(
      .LAYER (i),
      .NPL   (NODES_PER_LAYER),
      .AW    (AW),
      .NW    (NW),
      .HW    (HW),
      .LW    (LW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl_w[i]),
      .cur_i      (cur_w[i]),
      .addr_i     (addr_w[i]),
      .n_i        (n_w[i]),
      .hop_i      (hop_w[i]),
      .fill_nxt_i (fill_nxt),
      .ctl_o      (ctl_w[i + 1]),
      .cur_o      (cur_w[i + 1]),
      .addr_o     (addr_w[i + 1]),
      .n_o        (n_w[i + 1]),
      .hop_o      (hop_w[i + 1]),
      .fill_o     (fill_w[i])
    );
  end

  btrl_hop_table #(
    .NEXT_HOPS (NEXT_HOPS),
    .HW        (HW)
  ) u_hop_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (hop_ctl),
    .key_addr_i (in_hop_address),
    .key_port_i (in_hop_port),
    .lk_idx_i   (hop_w[LAYERS]),
    .stat_o     (hop_stat),
    .fidx_o     (hop_fidx),
    .count_o    (hop_count),
    .rd_addr_o  (hop_rd_addr),
    .rd_port_o  (hop_rd_port)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == OP_SEARCH) ? ST_SEARCH : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_ready) begin
          if ((full_r || ctl_w[LAYERS].full) || (!hop_stat.found && hop_stat.full)) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        if (wave_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SEARCH: begin
        if (wave_done) begin
          state_nxt = (hop_w[LAYERS] == '0) ? ST_RESP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    hop_ctl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        hop_ctl.start = accept && in_opcode == OP_INSERT;
      end
      ST_PROBE: begin
        hop_ctl.append = probe_ready && !(full_r || ctl_w[LAYERS].full)
                         && !hop_stat.found && !hop_stat.full;
      end
      ST_SEARCH: begin
        hop_ctl.lookup = wave_done && hop_w[LAYERS] != '0;
      end
      default: begin
        hop_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      launch_ctl_r <= '0;
      wdone_r      <= 1'b0;
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        wdone_r <= 1'b0;
        full_r  <= 1'b0;
      end else if (wave_done) begin
        wdone_r <= 1'b1;
        full_r  <= ctl_w[LAYERS].full;
      end
      if (accept) begin
        launch_ctl_r.vld    <= 1'b1;
        launch_ctl_r.mode   <= (in_opcode == OP_SEARCH) ? WAVE_SEARCH : WAVE_PROBE;
        launch_ctl_r.exists <= 1'b1;
        launch_ctl_r.full   <= 1'b0;
      end else if (state_r == ST_PROBE && state_nxt == ST_COMMIT) begin
        launch_ctl_r.vld    <= 1'b1;
        launch_ctl_r.mode   <= WAVE_COMMIT;
        launch_ctl_r.exists <= 1'b1;
        launch_ctl_r.full   <= 1'b0;
      end else begin
        launch_ctl_r.vld <= 1'b0;
      end
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: launch fields, result hold and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      launch_addr_r <= AW'(in_dest_address);
      launch_n_r    <= n_sat;
      launch_hop_r  <= '0;
    end
    case (state_r)
      ST_PROBE: begin
        launch_hop_r <= new_idx;
        res_addr_r   <= '0;
        res_port_r   <= '0;
        if (full_r || ctl_w[LAYERS].full) begin
          res_idx_r  <= '0;
          res_stat_r <= STAT_LAYER_FULL;
        end else if (!hop_stat.found && hop_stat.full) begin
          res_idx_r  <= '0;
          res_stat_r <= STAT_HOPS_FULL;
        end else begin
          res_idx_r  <= new_idx;
          res_stat_r <= STAT_OK;
        end
      end
      ST_SEARCH: begin
        res_idx_r  <= hop_w[LAYERS];
        res_addr_r <= '0;
        res_port_r <= '0;
        res_stat_r <= STAT_OK;
      end
      ST_LOOKUP: begin
        res_addr_r <= hop_rd_addr;
        res_port_r <= hop_rd_port;
      end
      ST_RESP: begin
        if (out_free) begin
          out_idx_r  <= 6'(res_idx_r);
          out_addr_r <= res_addr_r;
          out_port_r <= res_port_r;
          out_stat_r <= res_stat_r;
        end
      end
      default: begin
        res_stat_r <= res_stat_r;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_hop_index     = out_idx_r;
  assign out_found_address = out_addr_r;
  assign out_found_port    = out_port_r;
  assign out_status        = out_stat_r;

  `BTRL_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != ST_IDLE)
  `BTRL_ASSERT_IMP(a_fail_no_hop, clk, rst_n, out_valid && out_status != STAT_OK, out_hop_index == 6'd0 && out_found_address == 32'd0)
  `BTRL_ASSERT_IMP(a_one_wave, clk, rst_n, ctl_w[0].vld, !ctl_w[LAYERS].vld)
  `BTRL_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status == STAT_OK || out_status == STAT_LAYER_FULL || out_status == STAT_HOPS_FULL)

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the binary trie route lookup: directed table, then random traffic
`default_nettype none
module testbench import btrl_pkg::*; ();

  localparam int NODES = 1024;
  localparam int HOPS  = 63;
  localparam int ABITS = 32;
  localparam int POOL  = 90;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] addr;
    logic [7:0]  port;
    logic [1:0]  st;
  } route_res_t;

  typedef struct packed {
    logic        op;
    logic [31:0] dest;
    logic [5:0]  plen;
    logic [31:0] haddr;
    logic [7:0]  hport;
    logic        typed;
    route_res_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_SEARCH;
  logic [31:0] in_dest_address = '0;
  logic [5:0]  in_prefix_length = '0;
  logic [31:0] in_hop_address = '0;
  logic [7:0]  in_hop_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_hop_index;
  logic [31:0] out_found_address;
  logic [7:0]  out_found_port;
  logic [1:0]  out_status;

  binary_trie_route_lookup dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_dest_address(in_dest_address),
    .in_prefix_length(in_prefix_length), .in_hop_address(in_hop_address),
    .in_hop_port(in_hop_port),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hop_index(out_hop_index), .out_found_address(out_found_address),
    .out_found_port(out_found_port), .out_status(out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow trie
  int unsigned trie_kid [ABITS+1][NODES][2];
  int unsigned trie_hop [ABITS+1][NODES];
  int unsigned trie_fill [ABITS];
  logic [31:0] nh_addr [HOPS+1];
  logic [7:0]  nh_port [HOPS+1];
  int unsigned nh_count;

  route_res_t  expected_routes [$];
  logic [31:0] known_prefixes [$];
  logic [31:0] pool_addr [POOL];
  logic [7:0]  pool_port [POOL];
  int          mismatches = 0;
  int          idle_mode = 0;
  bit          hold_go = 1'b0;
  bit          fail_seen = 1'b0;

  function automatic route_res_t trie_insert(logic [31:0] dest, logic [5:0] plen,
                                             logic [31:0] ha, logic [7:0] hp);
    route_res_t r;
    int unsigned n, cur, c, miss, k, idx;
    bit hit;
    r = '0;
    n = (plen > ABITS) ? ABITS : plen;
    cur = 0;
    miss = n;
    for (int i = 0; i < n; i++) begin
      c = trie_kid[i][cur][dest[i]];
      if (c == 0) begin
        miss = i;
        break;
      end
      cur = c;
    end
    for (int i = miss; i < n; i++)
      if (trie_fill[i] >= NODES - 1) begin
        r.st = STAT_LAYER_FULL;
        return r;
      end
    idx = 0;
    hit = 1'b0;
    for (k = 1; k <= nh_count; k++)
      if (nh_addr[k] == ha && nh_port[k] == hp) begin
        idx = k;
        hit = 1'b1;
        break;
      end
    if (!hit) begin
      if (nh_count >= HOPS) begin
        r.st = STAT_HOPS_FULL;
        return r;
      end
      nh_count++;
      idx = nh_count;
      nh_addr[idx] = ha;
      nh_port[idx] = hp;
    end
    cur = 0;
    for (int i = 0; i < n; i++) begin
      c = trie_kid[i][cur][dest[i]];
      if (c == 0) begin
        trie_fill[i]++;
        c = trie_fill[i];
        trie_kid[i][cur][dest[i]] = c;
      end
      cur = c;
    end
    trie_hop[n][cur] = idx;
    r.idx = 6'(idx);
    r.st = STAT_OK;
    return r;
  endfunction

  function automatic route_res_t trie_search(logic [31:0] dest);
    route_res_t r;
    int unsigned cur, c, best;
    r = '0;
    cur = 0;
    best = trie_hop[0][0];
    for (int i = 0; i < ABITS; i++) begin
      c = trie_kid[i][cur][dest[i]];
      if (c == 0) break;
      cur = c;
      if (trie_hop[i+1][cur] != 0) best = trie_hop[i+1][cur];
    end
    if (best != 0) begin
      r.idx = 6'(best);
      r.addr = nh_addr[best];
      r.port = nh_port[best];
    end
    return r;
  endfunction

  // present one beat, hold until accepted, then queue its expected result
  task automatic send_beat(stim_row_t row);
    route_res_t r;
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 65 : (idle_mode == 3) ? 21 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= row.op;
    in_dest_address <= row.dest;
    in_prefix_length <= row.plen;
    in_hop_address <= row.haddr;
    in_hop_port <= row.hport;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.op == OP_INSERT) begin
      r = trie_insert(row.dest, row.plen, row.haddr, row.hport);
      if (r.st == STAT_OK) known_prefixes.push_back(row.dest);
    end else begin
      r = trie_search(row.dest);
    end
    expected_routes.push_back(row.typed ? row.res : r);
  endtask

  function automatic stim_row_t mk(logic op, logic [31:0] d, logic [5:0] pl,
                                   logic [31:0] ha, logic [7:0] hp);
    stim_row_t s;
    s = '0;
    s.op = op; s.dest = d; s.plen = pl; s.haddr = ha; s.hport = hp;
    return s;
  endfunction

  function automatic stim_row_t mkx(logic op, logic [31:0] d, logic [5:0] pl,
                                    logic [31:0] ha, logic [7:0] hp,
                                    logic [5:0] ei, logic [31:0] ea, logic [7:0] ep,
                                    logic [1:0] es);
    stim_row_t s;
    s = mk(op, d, pl, ha, hp);
    s.typed = 1'b1;
    s.res.idx = ei; s.res.addr = ea; s.res.port = ep; s.res.st = es;
    return s;
  endfunction

  // receiver: random stall, one long hold-off, and the output check
  int hold_left = 0;
  always @(posedge clk) begin
    route_res_t got, want;
    int stall_pct;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hop_index, out_found_address, out_found_port, out_status};
      if (expected_routes.size() == 0) begin
        fail_seen <= 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_routes.pop_front();
        if (got !== want) begin
          fail_seen <= 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: idx %0d/%0d addr %h/%h port %h/%h status %0d/%0d (exp/act)",
                     want.idx, got.idx, want.addr, got.addr, want.port, got.port,
                     want.st, got.st);
        end
      end
    end
    stall_pct = (idle_mode == 2) ? 65 : (idle_mode == 3) ? 21 : 0;
    if (hold_go && hold_left == 0 && !fail_seen && mismatches == 0 && hold_left != -1)
      hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_left = -1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #(12 * 1000000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stim_row_t plan [$];
    stim_row_t row;
    logic [31:0] d;
    int p, sh;
    for (int i = 0; i < POOL; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = 8'($urandom);
    end
    pool_addr[1] = 32'hFFFF_FFFF;
    pool_port[1] = 8'hFF;
    pool_addr[2] = 32'h0;
    pool_port[2] = 8'h0;
    nh_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan.push_back(mkx(OP_SEARCH, 32'h0, 6'd0, 32'h0, 8'h0, 6'd0, 32'h0, 8'h0, STAT_OK));
    plan.push_back(mkx(OP_SEARCH, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF,
                       6'd0, 32'h0, 8'h0, STAT_OK));
    // default route at the root
    plan.push_back(mkx(OP_INSERT, 32'h0, 6'd0, 32'hC0A8_0001, 8'd1,
                       6'd1, 32'h0, 8'h0, STAT_OK));
    plan.push_back(mkx(OP_SEARCH, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0,
                       6'd1, 32'hC0A8_0001, 8'd1, STAT_OK));
    plan.push_back(mkx(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 8'hFF,
                       6'd2, 32'h0, 8'h0, STAT_OK));
    plan.push_back(mkx(OP_SEARCH, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0,
                       6'd2, 32'hFFFF_FFFF, 8'hFF, STAT_OK));
    plan.push_back(mkx(OP_SEARCH, 32'h7FFF_FFFF, 6'd0, 32'h0, 8'h0,
                       6'd1, 32'hC0A8_0001, 8'd1, STAT_OK));
    // saturated prefix, same route again with an existing hop
    plan.push_back(mkx(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'hC0A8_0001, 8'd1,
                       6'd1, 32'h0, 8'h0, STAT_OK));
    plan.push_back(mkx(OP_SEARCH, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h0,
                       6'd1, 32'hC0A8_0001, 8'd1, STAT_OK));
    plan.push_back(mkx(OP_INSERT, 32'h0000_0005, 6'd3, 32'h0, 8'h0,
                       6'd3, 32'h0, 8'h0, STAT_OK));
    plan.push_back(mk(OP_SEARCH, 32'h0000_000D, 6'd0, 32'h0, 8'h0));
    plan.push_back(mk(OP_SEARCH, 32'h0000_0006, 6'd0, 32'h0, 8'h0));
    plan.push_back(mk(OP_INSERT, 32'h1234_5678, 6'd16, 32'h0A00_0001, 8'h80));
    plan.push_back(mk(OP_SEARCH, 32'hABCD_5678, 6'd0, 32'h0, 8'h0));
    plan.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 6'd1, 32'hFFFF_FFFF, 8'hFF));
    plan.push_back(mk(OP_SEARCH, 32'h0000_0001, 6'd0, 32'h0, 8'h0));
    plan.push_back(mk(OP_INSERT, 32'h0000_0000, 6'd32, 32'h5555_AAAA, 8'h5A));
    plan.push_back(mk(OP_SEARCH, 32'h0000_0000, 6'd33, 32'h0, 8'h0));
    plan.push_back(mk(OP_SEARCH, 32'hA5A5_A5A5, 6'd0, 32'h0, 8'h0));
    foreach (plan[i]) send_beat(plan[i]);

    hold_go = 1'b1;
    for (int n = 0; n < 760; n++) begin
      idle_mode = n / 190;
      if ($urandom_range(99) < 45) begin
        p = $urandom_range(99);
        row = mk(OP_INSERT, $urandom,
                 (p < 80) ? 6'($urandom_range(32)) : (p < 90) ? 6'($urandom_range(63, 33))
                                                      : 6'd32,
                 32'h0, 8'h0);
        sh = $urandom_range(POOL - 1);
        row.haddr = pool_addr[sh];
        row.hport = pool_port[sh];
        if ($urandom_range(99) < 5) begin
          row.haddr = $urandom;
          row.hport = 8'($urandom);
        end
      end else begin
        d = $urandom;
        if (known_prefixes.size() != 0 && $urandom_range(99) < 70) begin
          sh = $urandom_range(32);
          d = 32'((known_prefixes[$urandom_range(known_prefixes.size() - 1)]
                   & ((64'h1 << sh) - 1)) | (d & ~32'((64'h1 << sh) - 1)));
        end
        row = mk(OP_SEARCH, d, 6'($urandom), $urandom, 8'($urandom));
      end
      send_beat(row);
    end

    idle_mode = 0;
    for (int i = 0; i < 20; i++)
      send_beat(mk(OP_SEARCH, $urandom, 6'd0, 32'h0, 8'h0));
    in_valid <= 1'b0;

    while (expected_routes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!fail_seen && mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

// ===== binary_trie_route_lookup.f =====
+incdir+rtl/core
rtl/core/btrl_pkg.sv
rtl/core/btrl_cell.sv
rtl/core/btrl_hop_table.sv
rtl/core/binary_trie_route_lookup.sv
bench/testbench.sv
